// ===== rtl/core/fir101_pkg.sv =====
package fir101_pkg;

	localparam int TAPS         = 101;
	localparam int HALF_TAPS    = (TAPS + 1) / 2;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEFF_WIDTH  = 18;
	localparam int COEFF_FRAC   = COEFF_WIDTH - 1;
	localparam int ACC_WIDTH    = 40;
	localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEFF_WIDTH;
	localparam int TAP_W        = $clog2(TAPS);
	localparam int HALF_W       = $clog2(HALF_TAPS);
	localparam int SKIP_W       = 7;

	typedef logic        [TAP_W-1:0]        tap_t;
	typedef logic        [SKIP_W-1:0]       skip_t;
	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEFF_WIDTH-1:0]  coef_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;

	// Sequencer to multiply-accumulate unit.
	typedef struct packed {
		logic clear;  // zero the accumulator for a new sum
		logic issue;  // a tap read goes out this cycle
		tap_t tap;    // tap number of that read, newest sample is tap 0
	} mac_ctl_t;

	// Multiply-accumulate unit back to the sequencer.
	typedef struct packed {
		logic    busy;       // taps still in the multiply or add stage
		sample_t filtered;   // rounded, saturated sum
		logic    saturated;
	} mac_sts_t;

	// Symmetric lowpass ROM, Q1.17: fold the tap onto the first half.
	function automatic coef_t coef_at(tap_t tap);
		logic [HALF_W-1:0] k;
		coef_t             c;
		k = (int'(tap) < HALF_TAPS) ? tap[HALF_W-1:0] : HALF_W'(TAPS - 1 - int'(tap));
		case (k)
			6'd0:  c = coef_t'(67);
			6'd1:  c = coef_t'(49);
			6'd2:  c = coef_t'(0);
			6'd3:  c = coef_t'(-55);
			6'd4:  c = coef_t'(-86);
			6'd5:  c = coef_t'(-67);
			6'd6:  c = coef_t'(0);
			6'd7:  c = coef_t'(85);
			6'd8:  c = coef_t'(136);
			6'd9:  c = coef_t'(109);
			6'd10: c = coef_t'(0);
			6'd11: c = coef_t'(-141);
			6'd12: c = coef_t'(-225);
			6'd13: c = coef_t'(-179);
			6'd14: c = coef_t'(1);
			6'd15: c = coef_t'(228);
			6'd16: c = coef_t'(360);
			6'd17: c = coef_t'(284);
			6'd18: c = coef_t'(-1);
			6'd19: c = coef_t'(-353);
			6'd20: c = coef_t'(-553);
			6'd21: c = coef_t'(-432);
			6'd22: c = coef_t'(1);
			6'd23: c = coef_t'(528);
			6'd24: c = coef_t'(820);
			6'd25: c = coef_t'(636);
			6'd26: c = coef_t'(-2);
			6'd27: c = coef_t'(-767);
			6'd28: c = coef_t'(-1187);
			6'd29: c = coef_t'(-918);
			6'd30: c = coef_t'(2);
			6'd31: c = coef_t'(1102);
			6'd32: c = coef_t'(1705);
			6'd33: c = coef_t'(1319);
			6'd34: c = coef_t'(-2);
			6'd35: c = coef_t'(-1595);
			6'd36: c = coef_t'(-2482);
			6'd37: c = coef_t'(-1937);
			6'd38: c = coef_t'(3);
			6'd39: c = coef_t'(2400);
			6'd40: c = coef_t'(3804);
			6'd41: c = coef_t'(3040);
			6'd42: c = coef_t'(-3);
			6'd43: c = coef_t'(-4030);
			6'd44: c = coef_t'(-6726);
			6'd45: c = coef_t'(-5763);
			6'd46: c = coef_t'(3);
			6'd47: c = coef_t'(9751);
			6'd48: c = coef_t'(20775);
			6'd49: c = coef_t'(29459);
			6'd50: c = coef_t'(32750);
			default: c = coef_t'(0);
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/fir101_in_if.sv =====
interface fir101_in_if import fir101_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    stream_start;

	modport source (output valid, output sample, output stream_start, input ready);
	modport sink   (input valid, input sample, input stream_start, output ready);
endinterface

// ===== rtl/core/fir101_out_if.sv =====
interface fir101_out_if import fir101_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t filtered;
	logic    saturated;

	modport source (output valid, output filtered, output saturated, input ready);
	modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

// ===== rtl/core/fir101_dline.sv =====
// Delay line: one write port, one registered read port, a valid bit per entry.
module fir101_dline import fir101_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    clr,
	input  logic    we,
	input  tap_t    waddr,
	input  sample_t wdata,
	input  tap_t    raddr,
	output sample_t rdata
);

	sample_t          mem [TAPS];
	logic [TAPS-1:0]  vld_q;
	logic [TAPS-1:0]  vld_set;
	sample_t          rdata_q;
	logic             rvld_q;

	assign vld_set = we ? ({{(TAPS-1){1'b0}}, 1'b1} << waddr) : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Clear drops every entry at once; a write in the same cycle still lands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			vld_q  <= (clr ? '0 : vld_q) | vld_set;
			rvld_q <= vld_q[raddr];
		end
	end

	// Never-written entries read as zero.
	assign rdata = rvld_q ? rdata_q : sample_t'(0);

endmodule

// ===== rtl/core/fir101_mac.sv =====
// Shared multiply-accumulate: coefficient lookup, product stage, 40-bit sum.
module fir101_mac import fir101_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_ctl_t ctl,
	input  sample_t  rd_data,
	output mac_sts_t sts
);

	localparam int RND_W = ACC_WIDTH - COEFF_FRAC;
	localparam logic signed [RND_W-1:0] RND_MAX = RND_W'((1 <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [RND_W-1:0] RND_MIN = -RND_MAX - RND_W'(1);
	localparam acc_t RND_HALF = acc_t'(1) <<< (COEFF_FRAC - 1);

	coef_t coef_s1;
	logic  en_s1;
	prod_t prod_s2;
	logic  en_s2;
	acc_t  acc_q;

	acc_t                    biased;
	logic signed [RND_W-1:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
		end else begin
			en_s1 <= ctl.issue;
			en_s2 <= en_s1;
		end
	end

	// Coefficient lines up with the registered memory read.
	always_ff @(posedge clk) begin
		coef_s1 <= coef_at(ctl.tap);
		prod_s2 <= prod_t'(rd_data) * prod_t'(coef_s1);
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (en_s2) begin
			acc_q <= acc_q + acc_t'(prod_s2);
		end
	end

	// Round half up: floor((acc + 2^16) / 2^17), then clamp to Q1.15.
	always_comb begin
		biased = acc_q + RND_HALF;
		rnd    = signed'(biased[ACC_WIDTH-1:COEFF_FRAC]);
		sts.busy = en_s1 | en_s2;
		if (rnd > RND_MAX) begin
			sts.filtered  = RND_MAX[SAMPLE_WIDTH-1:0];
			sts.saturated = 1'b1;
		end else if (rnd < RND_MIN) begin
			sts.filtered  = RND_MIN[SAMPLE_WIDTH-1:0];
			sts.saturated = 1'b1;
		end else begin
			sts.filtered  = rnd[SAMPLE_WIDTH-1:0];
			sts.saturated = 1'b0;
		end
	end

endmodule

// ===== rtl/core/fir_lowpass_101_tap_core.sv =====
// 101-tap symmetric FIR lowpass on Q1.15 audio samples. Each transfer on
// audio writes one sample into a circular delay line held in a single-port-
// read memory, then one shared multiplier walks all 101 taps, newest first,
// against a Q1.17 coefficient ROM and sums into a 40-bit accumulator. From its
// transfer to the earliest next transfer, an item passes through the transfer
// cycle, which writes the sample, a read of every tap (one tap per cycle
// through the read port), and a drain of the read, multiply and add stages;
// audio.ready returns when the core goes back to idle. The sum
// is rounded half up to Q1.15 and clamped, with saturated flagging the clamp.
// The first skip_outputs results of each stream (cfg_wdata, reset 50) produce
// no transfer on result. stream_start clears the delay line and the skip
// count in the same cycle through per-entry valid bits, so no clearing pass
// is needed. A finished result sits in an output register, so the next sample
// may transfer while result is stalled; a second result then holds in the
// drain until the output register frees. Write cfg only while idle.
module fir_lowpass_101_tap_core import fir101_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  skip_t           cfg_wdata,
	fir101_in_if.sink       audio,
	fir101_out_if.source    result
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	localparam tap_t LAST_TAP = TAP_W'(TAPS - 1);

	state_t   state_q;
	tap_t     wp_q;
	tap_t     rd_idx_q;
	tap_t     tap_q;
	skip_t    skip_q;
	skip_t    skipped_q;
	logic     emit_q;
	logic     out_valid_q;
	sample_t  filtered_q;
	logic     saturated_q;

	logic     accept;
	tap_t     wp_eff;
	skip_t    skipped_eff;
	logic     emit_now;
	logic     load_out;
	mac_ctl_t mac_ctl;
	mac_sts_t mac_sts;
	sample_t  rd_data;

	assign audio.ready = (state_q == ST_IDLE);
	assign accept      = audio.valid && audio.ready;

	// Stream start behaves as if the buffer and counters were just zeroed.
	assign wp_eff      = audio.stream_start ? tap_t'(0) : wp_q;
	assign skipped_eff = audio.stream_start ? skip_t'(0) : skipped_q;
	assign emit_now    = (skipped_eff >= skip_q);

	// Load the result once the last product has landed in the accumulator.
	assign load_out = (state_q == ST_DRAIN) && !mac_sts.busy && emit_q
	                  && (!out_valid_q || result.ready);

	assign mac_ctl.clear = accept;
	assign mac_ctl.issue = (state_q == ST_RUN);
	assign mac_ctl.tap   = tap_q;

	// The sample is written in the transfer cycle and first read in the next
	// cycle, so reads never overlap the write to the same entry.
	fir101_dline u_dline (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept && audio.stream_start),
		.we     (accept),
		.waddr  (wp_eff),
		.wdata  (audio.sample),
		.raddr  (rd_idx_q),
		.rdata  (rd_data)
	);

	fir101_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.rd_data (rd_data),
		.sts     (mac_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= skip_t'(50);
		end else if (cfg_we) begin
			skip_q <= cfg_wdata;
		end
	end

	// Sequencer: write, walk the taps, drain, hand off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			rd_idx_q  <= '0;
			tap_q     <= '0;
			skipped_q <= '0;
			emit_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q  <= wp_eff;
						tap_q     <= '0;
						wp_q      <= (wp_eff == LAST_TAP) ? tap_t'(0) : wp_eff + 1'b1;
						emit_q    <= emit_now;
						skipped_q <= emit_now ? skipped_eff : skipped_eff + 1'b1;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					// Step back through the ring, one tap per read.
					rd_idx_q <= (rd_idx_q == '0) ? LAST_TAP : rd_idx_q - 1'b1;
					if (tap_q == LAST_TAP) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// Drop suppressed results; hold a real one until the output frees.
					if (!mac_sts.busy && (!emit_q || load_out)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filtered_q  <= mac_sts.filtered;
			saturated_q <= mac_sts.saturated;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.filtered  = filtered_q;
	assign result.saturated = saturated_q;

	// The tap walk ends after exactly TAPS reads.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (tap_q == LAST_TAP) |=> (state_q == ST_DRAIN))
		else $error("tap walk did not end after the last tap");

	// Never hand off a sum that still has products in flight.
	a_load_final: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !mac_sts.busy && !mac_ctl.issue)
		else $error("result loaded before the accumulator settled");

	// Write pointer stays inside the ring.
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST_TAP)
		else $error("write pointer left the delay line");

	// A stream start puts its sample at entry zero.
	a_start_wp: assert property (@(posedge clk) disable iff (!arst_n)
		accept && audio.stream_start |=> (wp_q == tap_t'(1)) && (rd_idx_q == '0))
		else $error("stream start did not restart the ring");

endmodule

// ===== dv/fir_lowpass_101_tap_core_test.sv =====
module fir_lowpass_101_tap_core_test import fir101_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// SETTLE_CYCLES is a little more than one item's time in the core; wait it
	// out before a register write or the final verdict.
	localparam int SETTLE_CYCLES  = 120;
	// Longest legal stretch without a transfer is a long receiver hold-off plus
	// one item. Allow several times that.
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [7:0] KEEP_SKIP = 8'hFF;  // no register write before the row
	localparam sample_t SAMPLE_MAX = sample_t'(2 ** (SAMPLE_WIDTH - 1) - 1);
	localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_WIDTH - 1)));
	localparam longint  ROUND_HALF = longint'(1) << (COEFF_FRAC - 1);

	typedef struct packed {
		sample_t filtered;
		logic    saturated;
	} filt_result_t;

	typedef struct packed {
		logic [7:0] skip_wr;       // KEEP_SKIP, or the new skip_outputs value
		sample_t    sample;
		logic       start;
		logic       typed;         // exp_* below holds the expected result
		sample_t    exp_filtered;
		logic       exp_saturated;
	} dir_row_t;

	typedef enum int {
		STIM_RANDOM,
		STIM_QUIET,
		STIM_DC,
		STIM_SAT_PATTERN,
		STIM_EDGES
	} stim_kind_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	skip_t cfg_wdata;

	fir101_in_if  audio_if ();
	fir101_out_if result_if ();

	fir_lowpass_101_tap_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.audio     (audio_if),
		.result    (result_if)
	);

	// Lowpass ROM, first half plus center tap, Q1.17. The second half mirrors it.
	int lowpass_half [0:HALF_TAPS-1] = '{
		67, 49, 0, -55, -86, -67, 0, 85, 136, 109,
		0, -141, -225, -179, 1, 228, 360, 284, -1, -353,
		-553, -432, 1, 528, 820, 636, -2, -767, -1187, -918,
		2, 1102, 1705, 1319, -2, -1595, -2482, -1937, 3, 2400,
		3804, 3040, -3, -4030, -6726, -5763, 3, 9751, 20775, 29459,
		32750
	};

	// Predictor state: a mirror of the core's delay line and skip bookkeeping.
	sample_t taps_hist [0:TAPS-1];
	int      hist_wr;
	int      skipped;
	int      skip_setting;

	filt_result_t pending_results [$];
	int           errors;
	int           send_idle;
	int           recv_idle;
	int           hold_left;
	int           quiet_cycles;

	// Directed rows. The stream opens under the reset skip count of 50, so the
	// first two samples are swallowed; lowering the count to zero then lets
	// results resume mid-stream. Single-sample streams give results that are
	// just the newest sample times the first coefficient, typed in below.
	dir_row_t dir_rows [0:21] = '{
		'{KEEP_SKIP, sample_t'(0),      1'b1, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(12345),  1'b0, 1'b0, sample_t'(0),   1'b0},
		'{8'd0,      sample_t'(-1),     1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(0),      1'b1, 1'b1, sample_t'(0),   1'b0},
		'{KEEP_SKIP, SAMPLE_MAX,        1'b1, 1'b1, sample_t'(17),  1'b0},
		'{KEEP_SKIP, SAMPLE_MIN,        1'b1, 1'b1, sample_t'(-17), 1'b0},
		'{KEEP_SKIP, SAMPLE_MIN,        1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, SAMPLE_MAX,        1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, SAMPLE_MAX,        1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(1),      1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(21845),  1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(-21846), 1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(-1),     1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(0),      1'b0, 1'b0, sample_t'(0),   1'b0},
		'{8'd100,    SAMPLE_MAX,        1'b1, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, SAMPLE_MIN,        1'b0, 1'b0, sample_t'(0),   1'b0},
		'{8'd127,    sample_t'(5),      1'b1, 1'b0, sample_t'(0),   1'b0},
		'{8'd1,      SAMPLE_MIN,        1'b1, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, SAMPLE_MIN,        1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, SAMPLE_MAX,        1'b0, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(4660),   1'b1, 1'b0, sample_t'(0),   1'b0},
		'{KEEP_SKIP, sample_t'(-4661),  1'b0, 1'b0, sample_t'(0),   1'b0}
	};

	// Coefficient of tap j, tap 0 being the newest sample.
	function automatic int lowpass_coef(int j);
		return lowpass_half[(j < HALF_TAPS) ? j : TAPS - 1 - j];
	endfunction

	// Advance the filter by one sample. Returns 1 when a result leaves the
	// core, with the result in r; 0 while the stream is still being skipped.
	function automatic bit filter_step(sample_t s, logic st, output filt_result_t r);
		longint acc;
		longint rounded;
		int     idx;
		if (st) begin
			foreach (taps_hist[i]) taps_hist[i] = '0;
			hist_wr = 0;
			skipped = 0;
		end
		taps_hist[hist_wr] = s;
		acc = 0;
		idx = hist_wr;
		for (int j = 0; j < TAPS; j++) begin
			acc += longint'(taps_hist[idx]) * longint'(lowpass_coef(j));
			idx = (idx == 0) ? TAPS - 1 : idx - 1;
		end
		hist_wr = (hist_wr == TAPS - 1) ? 0 : hist_wr + 1;
		r = '0;
		if (skipped < skip_setting) begin
			skipped++;
			return 1'b0;
		end
		// Arithmetic shift floors, so adding half first rounds half up.
		rounded = (acc + ROUND_HALF) >>> COEFF_FRAC;
		if (rounded > longint'(SAMPLE_MAX)) begin
			r.filtered  = SAMPLE_MAX;
			r.saturated = 1'b1;
		end else if (rounded < longint'(SAMPLE_MIN)) begin
			r.filtered  = SAMPLE_MIN;
			r.saturated = 1'b1;
		end else begin
			r.filtered  = sample_t'(rounded);
		end
		return 1'b1;
	endfunction

	// Free-running clock, 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: drive ready at the falling edge. A long hold-off requested by
	// the stimulus takes priority over the random stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Result checker: compare every result transfer with the oldest prediction.
	always @(posedge clk) begin
		filt_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: filtered %0d saturated %0b",
					result_if.filtered, result_if.saturated);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result_if.filtered !== want.filtered) begin
					$error("filtered: expected %0d, got %0d",
						want.filtered, result_if.filtered);
					errors++;
				end
				if (result_if.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b",
						want.saturated, result_if.saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (audio_if.valid && audio_if.ready)
				|| (result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample on audio, after a random gap, and hold it until the
	// transfer. On the transfer, advance the predictor and queue its result;
	// a typed row queues the typed result instead. Enter and leave at a
	// falling edge.
	task automatic offer_sample(sample_t s, logic st, logic typed = 1'b0,
			filt_result_t typed_res = '0);
		int           gap;
		filt_result_t r;
		gap = 0;
		while ($urandom_range(99) < send_idle) gap++;
		if (gap > 0) begin
			audio_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		audio_if.valid        = 1'b1;
		audio_if.sample       = s;
		audio_if.stream_start = st;
		do @(posedge clk); while (!audio_if.ready);
		if (filter_step(s, st, r)) begin
			pending_results.insert(pending_results.size(), typed ? typed_res : r);
		end
		@(negedge clk);
	endtask

	// Drop valid and wait for every predicted result to come back.
	task automatic drain_results();
		audio_if.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Write skip_outputs while the core is idle. A suppressed item leaves no
	// result to wait for, so let one item time pass after the queue empties.
	task automatic write_skip(int value);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we       = 1'b1;
		cfg_wdata    = skip_t'(value);
		skip_setting = value;
		@(negedge clk);
		cfg_we       = 1'b0;
	endtask

	function automatic sample_t make_sample(stim_kind_t kind, int pos, bit pol);
		int c;
		case (kind)
			STIM_QUIET: return sample_t'(int'($urandom_range(0, 512)) - 256);
			STIM_DC: return pol ? SAMPLE_MAX : SAMPLE_MIN;
			STIM_SAT_PATTERN: begin
				// Match every tap's sign; with a symmetric ROM the match
				// recurs once per 101 samples and drives the sum to clamp.
				c = lowpass_coef(pos % TAPS);
				if (c == 0) return sample_t'($urandom);
				return ((c > 0) ^ pol) ? SAMPLE_MAX : SAMPLE_MIN;
			end
			STIM_EDGES: begin
				case ($urandom_range(4))
					0: return SAMPLE_MAX;
					1: return SAMPLE_MIN;
					2: return sample_t'(0);
					3: return sample_t'(-1);
					default: return sample_t'(1);
				endcase
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	// One random phase: set the register and idle rates, then send streams
	// until the item count is met. Most streams run well past the skip count;
	// a few are short and cut off.
	task automatic run_phase(int skip, int s_idle, int r_idle, int n_items,
			int hold_len, bit pause_mid);
		int         sent;
		int         len;
		int         streams;
		bit         pol;
		logic       st;
		stim_kind_t kind;
		write_skip(skip);
		send_idle    = s_idle;
		recv_idle    = r_idle;
		hold_left    = hold_len;
		sent         = 0;
		streams      = 0;
		while (sent < n_items) begin
			kind = stim_kind_t'($urandom_range(STIM_EDGES));
			pol  = $urandom_range(1);
			if ($urandom_range(99) < 80) len = skip + $urandom_range(10, 130);
			else len = $urandom_range(1, 20);
			for (int i = 0; i < len && sent < n_items; i++) begin
				// The first stream of a phase may carry on from the previous
				// one, so a changed skip count applies mid-stream.
				if (i == 0) st = (streams == 0) ? logic'($urandom_range(1)) : 1'b1;
				else st = ($urandom_range(199) == 0);
				offer_sample(make_sample(kind, i, pol), st);
				sent++;
			end
			streams++;
			if (pause_mid && streams == 1) drain_results();
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		audio_if.valid        = 1'b0;
		audio_if.sample       = '0;
		audio_if.stream_start = 1'b0;
		result_if.ready       = 1'b0;
		errors                = 0;
		hold_left             = 0;
		quiet_cycles          = 0;
		send_idle             = 15;
		recv_idle             = 55;
		foreach (taps_hist[i]) taps_hist[i] = '0;
		hist_wr               = 0;
		skipped               = 0;
		skip_setting          = 50;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: walk the table, writing the register where a row asks.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].skip_wr != KEEP_SKIP) write_skip(int'(dir_rows[i].skip_wr));
			offer_sample(dir_rows[i].sample, dir_rows[i].start, dir_rows[i].typed,
				filt_result_t'{filtered: dir_rows[i].exp_filtered,
					saturated: dir_rows[i].exp_saturated});
		end

		// Random part. Sender idles less than the receiver first, then the
		// reverse, then neither idles. The third phase holds the receiver off
		// long enough to back the core up into audio.ready; the second pauses
		// the sender until every result is home.
		run_phase(50,  15, 55, 300, 0,   1'b0);
		run_phase(127, 15, 55, 250, 0,   1'b1);
		run_phase(0,   55, 15, 300, 900, 1'b0);
		run_phase(100, 55, 15, 250, 0,   1'b0);
		run_phase($urandom_range(0, 127), 0, 0, 280, 0, 1'b0);
		run_phase(3,   0,  0,  300, 0,   1'b0);

		// Wait out the last results, then one more item time for stray output.
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/fir101_pkg.sv
rtl/core/fir101_in_if.sv
rtl/core/fir101_out_if.sv
rtl/core/fir101_dline.sv
rtl/core/fir101_mac.sv
rtl/core/fir_lowpass_101_tap_core.sv
dv/fir_lowpass_101_tap_core_test.sv
